FILE: hw/rtl/bdq_pkg.sv
// Shared types, codes and widths of the bounded deque with search.
package bdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 72;
    localparam int M_USER_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CONTAINS   = 3'd4,
        CMD_REMOVE     = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_FETCH,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic shift;
        logic fetch;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic hit;
        logic drained;
    } t_dp_stat;

endpackage

FILE: hw/rtl/bdq_datapath.sv
// Ring storage, pointers, scan and shift engine and result register of the deque.
module bdq_datapath #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = bdq_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bdq_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic [bdq_pkg::S_USER_W-1:0]  i_s_tuser,
    input  bdq_pkg::t_dp_cmd              i_cmd,
    output bdq_pkg::t_dp_stat             o_stat,
    output logic [bdq_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [bdq_pkg::M_USER_W-1:0]  o_m_tuser
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(pos);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] to_store(input logic [VALUE_W-1:0] x);
        logic signed [63:0] w;
        w = 64'(signed'(x));
        return w[VALUE_BITS-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] widen(input logic [VALUE_BITS-1:0] d);
        logic signed [63:0] w;
        w = 64'(signed'(d));
        return w[VALUE_W-1:0];
    endfunction

    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_rd_pos;
    logic                  r_rd_vld;
    t_cmd                  r_cmd;
    t_status               r_status;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_val;
    logic [VALUE_BITS-1:0] r_rdata;
    logic [VALUE_BITS-1:0] r_rdata_b;
    logic [VALUE_W-1:0]    r_out_front;
    logic [VALUE_W-1:0]    r_out_back;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_found;
    t_status               r_out_status;

    logic                  empty;
    logic                  full;
    logic                  hit;
    logic                  drained;
    logic                  issue;
    logic                  rd_en_a;
    logic [AW-1:0]         rd_addr_a;
    logic [CW-1:0]         back_pos;
    logic [AW-1:0]         head_dec;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [CW+COUNT_W-1:0] count_ext;

    assign empty    = (r_count == '0);
    assign full     = (r_count == CW'(DEPTH));
    assign hit      = r_rd_vld && (r_rdata == r_val);
    assign drained  = !r_rd_vld && (r_pos == r_count);
    assign issue    = ((i_cmd.scan && !hit) || i_cmd.shift) && (r_pos != r_count);
    assign rd_en_a  = issue || i_cmd.fetch;
    assign rd_addr_a = i_cmd.fetch ? r_head : slot(r_head, r_pos);
    assign back_pos = empty ? '0 : r_count - CW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign count_ext = (CW+COUNT_W)'(r_count);

    always_comb begin
        we    = 1'b0;
        waddr = slot(r_head, r_count);
        wdata = r_val;
        if (i_cmd.exec && !full) begin
            case (r_cmd)
                CMD_PUSH_FRONT: begin
                    we    = 1'b1;
                    waddr = head_dec;
                end
                CMD_PUSH_BACK: begin
                    we = 1'b1;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
        // move the word read last cycle one place toward the front
        if (i_cmd.shift && r_rd_vld) begin
            we    = 1'b1;
            waddr = slot(r_head, r_rd_pos - CW'(1));
            wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_rd_pos <= '0;
            r_rd_vld <= 1'b0;
            r_cmd    <= CMD_PUSH_FRONT;
            r_status <= ST_OK;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmd    <= t_cmd'(i_s_tuser);
                r_status <= ST_OK;
                r_found  <= 1'b0;
                r_pos    <= '0;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_cmd)
                    CMD_PUSH_FRONT: begin
                        if (full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_head  <= head_dec;
                            r_count <= r_count + CW'(1);
                        end
                    end
                    CMD_PUSH_BACK: begin
                        if (full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    CMD_POP_FRONT: begin
                        if (empty) begin
                            r_status <= ST_EMPTY;
                        end else begin
                            r_head  <= slot(r_head, CW'(1));
                            r_count <= r_count - CW'(1);
                        end
                    end
                    CMD_POP_BACK: begin
                        if (empty) begin
                            r_status <= ST_EMPTY;
                        end else begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (empty) begin
                            r_status <= ST_EMPTY;
                        end
                    end
                    default: begin
                        r_status <= ST_OK;
                    end
                endcase
            end
            if (i_cmd.scan || i_cmd.shift) begin
                if (i_cmd.scan && hit) begin
                    // restart the read pointer just past the match for the shift
                    r_found  <= 1'b1;
                    r_pos    <= r_rd_pos + CW'(1);
                    r_rd_vld <= 1'b0;
                end else if (issue) begin
                    r_rd_pos <= r_pos;
                    r_pos    <= r_pos + CW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.shift && drained) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val <= to_store(i_s_tdata);
        end
        if (rd_en_a) begin
            r_rdata <= r_mem[rd_addr_a];
        end
        if (i_cmd.fetch) begin
            r_rdata_b <= r_mem[slot(r_head, back_pos)];
        end
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.out_load) begin
            r_out_front  <= empty ? '0 : widen(r_rdata);
            r_out_back   <= empty ? '0 : widen(r_rdata_b);
            r_out_count  <= count_ext[COUNT_W-1:0];
            r_out_found  <= r_found;
            r_out_status <= r_status;
        end
    end

    assign o_stat.cmd     = r_cmd;
    assign o_stat.empty   = empty;
    assign o_stat.hit     = hit;
    assign o_stat.drained = drained;

    assign o_m_tdata = {3'b000, r_out_count, r_out_back, r_out_front};
    assign o_m_tuser = {r_out_status, r_out_found};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_status == ST_OK))
        else $error("match reported together with a refusal");

endmodule

FILE: hw/rtl/bdq_ctrl.sv
// Sequencer of the deque: one command at a time through execute, scan, shift and fetch.
module bdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  bdq_pkg::t_dp_stat i_stat,
    output bdq_pkg::t_dp_cmd  o_cmd
);
    import bdq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_m_tvalid;
    logic   n_m_tvalid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((i_stat.cmd inside {CMD_CONTAINS, CMD_REMOVE}) && !i_stat.empty) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = (i_stat.cmd == CMD_REMOVE) ? S_SHIFT : S_FETCH;
                end else if (i_stat.drained) begin
                    n_state = S_FETCH;
                end
            end
            S_SHIFT: begin
                if (i_stat.drained) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the result slot is free
                if (!r_m_tvalid || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_s_tready     = 1'b0;
        n_m_tvalid     = r_m_tvalid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_tvalid     = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    assign o_m_tvalid = r_m_tvalid;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_EXEC))
        else $error("accepted word not executed next cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_m_tvalid && !i_m_tready) |=> (r_state == S_OUT))
        else $error("result overwritten while the previous one waits");

endmodule

FILE: hw/rtl/bounded_deque_with_search.sv
// Sequence: a taken word passes through the execute, fetch and output states, and no new
// word is taken until its result is loaded into the output register. Contains also walks
// the entries until a match or the back; remove also walks, then moves each entry behind
// the match one place toward the front, as one read port serves both search and gap closing. A
// finished result waits in the output register while the next word is taken.
// Reset (i_rst_n low, synchronous) empties the queue; the ring storage is not cleared.
module bounded_deque_with_search #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = bdq_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bdq_pkg::S_DATA_W-1:0]  i_s_tdata,  // value[31:0]
    input  logic [bdq_pkg::S_USER_W-1:0]  i_s_tuser,  // cmd[2:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bdq_pkg::M_DATA_W-1:0]  o_m_tdata,  // front[31:0], back[63:32],
                                                      // count[68:64], zero[71:69]
    output logic [bdq_pkg::M_USER_W-1:0]  o_m_tuser   // found[0], status[2:1]
);
    import bdq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

endmodule
